>>> rtl/core/irt_pkg.sv
// Shared types and constants for the I/O range reservation table.
package irt_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int HANDLE_W      = 5;

  localparam logic [1:0]  KIND_MEM        = 2'd0;
  localparam logic [1:0]  KIND_PORT       = 2'd1;
  localparam logic [1:0]  KIND_DMA        = 2'd2;
  localparam logic [31:0] DMA_MAX_CHANNEL = 32'd8;
  localparam logic [31:0] DMA_LENGTH      = 32'd1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_BUSY = 2'd2,
    ST_FULL = 2'd3
  } resp_code_t;

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                cmd;
    logic [1:0]          range_kind;
    logic [31:0]         range_base;
    logic [31:0]         range_length;
    logic [HANDLE_W-1:0] release_slot;
  } in_word_t;

  typedef struct packed {
    resp_code_t          status;
    logic [HANDLE_W-1:0] granted_slot;
  } out_word_t;

  // request token walking down the cell chain
  typedef struct packed {
    logic             valid;
    logic [1:0]       kind;
    logic [31:0]      first;
    logic [31:0]      last;
    logic             busy;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } token_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [1:0]       kind;
    logic [31:0]      first;
    logic [31:0]      last;
  } commit_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } release_t;

endpackage

>>> rtl/core/io_range_reservation_table.sv
// Top level: request check, cell chain and result sequencing.
// Results: a release or rejected acquire goes to the result register, then to
// the output register; a checked acquire first walks the chain to its tail.
// Throughput: one request at a time; the token passes one cell per cycle,
// and the output register frees the input.
// Reset: synchronous rst_n clears all slot valid marks and control state at once.
module io_range_reservation_table import irt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  state_t    state_r;
  state_t    state_nxt;
  token_t    head_r;
  token_t    head_nxt;
  token_t    chain [TABLE_ENTRIES+1];
  token_t    tail;
  logic [TABLE_ENTRIES-1:0] valid_vec;

  out_word_t res_r;
  out_word_t res_nxt;
  logic      res_load;
  logic      pend_r;
  logic      pend_nxt;
  commit_t   com_r;
  commit_t   com_nxt;
  commit_t   commit;
  release_t  rel;

  logic      out_valid_r;
  logic      out_valid_nxt;
  out_word_t out_data_r;
  logic      out_load;
  logic      in_fire;

  logic [32:0] sum;
  logic [31:0] len_m1;
  logic        req_ok;
  logic [31:0] req_last;

  // request check
  assign sum    = {1'b0, in_data.range_base} + {1'b0, in_data.range_length};
  assign len_m1 = in_data.range_length - 32'd1;

  always_comb begin
    req_ok   = 1'b0;
    req_last = in_data.range_base + len_m1;
    case (in_data.range_kind)
      KIND_MEM:  req_ok = !sum[32] && (in_data.range_length != 32'd0);
      KIND_PORT: req_ok = (in_data.range_base[31:16] == 16'd0) &&
                          (in_data.range_length[31:16] == 16'd0) &&
                          (in_data.range_length != 32'd0);
      KIND_DMA: begin
        req_ok   = in_data.range_base <= DMA_MAX_CHANNEL;
        req_last = in_data.range_base + (DMA_LENGTH - 32'd1);
      end
      default:   req_ok = 1'b0;
    endcase
  end

  assign in_fire  = in_valid && in_ready;
  assign tail     = chain[TABLE_ENTRIES];
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.cmd == CMD_ACQUIRE && req_ok) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: if (tail.valid) state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready         = 1'b0;
    rel              = '0;
    head_nxt         = '0;
    res_load         = 1'b0;
    res_nxt          = '{status: ST_OK, granted_slot: '0};
    pend_nxt         = pend_r;
    com_nxt          = com_r;
    commit           = com_r;
    commit.en        = out_load && pend_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          res_load = 1'b1;
          pend_nxt = 1'b0;
          if (in_data.cmd == CMD_RELEASE) begin
            rel.en  = ({{(32-HANDLE_W){1'b0}}, in_data.release_slot} <
                       32'(TABLE_ENTRIES));
            rel.idx = IDX_W'(in_data.release_slot);
          end else if (!req_ok) begin
            res_nxt.status = ST_BAD;
          end else begin
            head_nxt.valid      = 1'b1;
            head_nxt.kind       = in_data.range_kind;
            head_nxt.first      = in_data.range_base;
            head_nxt.last       = req_last;
            head_nxt.busy       = 1'b0;
            head_nxt.free_found = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (tail.valid) begin
          res_load = 1'b1;
          if (tail.busy) begin
            res_nxt.status = ST_BUSY;
          end else if (!tail.free_found) begin
            res_nxt.status = ST_FULL;
          end else begin
            res_nxt.granted_slot = HANDLE_W'(tail.free_idx);
          end
          pend_nxt      = !tail.busy && tail.free_found;
          com_nxt.idx   = tail.free_idx;
          com_nxt.kind  = tail.kind;
          com_nxt.first = tail.first;
          com_nxt.last  = tail.last;
        end
      end
      S_DONE: begin
        if (out_load) pend_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r.valid <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r.valid <= head_nxt.valid;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    head_r.kind       <= head_nxt.kind;
    head_r.first      <= head_nxt.first;
    head_r.last       <= head_nxt.last;
    head_r.busy       <= head_nxt.busy;
    head_r.free_found <= head_nxt.free_found;
    head_r.free_idx   <= head_nxt.free_idx;
    com_r             <= com_nxt;
    if (res_load) res_r <= res_nxt;
    if (out_load) out_data_r <= res_r;
  end

  assign chain[0] = head_r;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    irt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .tok_i    (chain[i]),
      .commit_i (commit),
      .rel_i    (rel),
      .tok_o    (chain[i+1]),
      .valid_o  (valid_vec[i])
    );
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a token only reaches the end of the chain while a scan is pending
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> state_r == S_SCAN)
    else $error("token left chain outside scan");

  // never grant a slot that is already taken
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    commit.en |-> !valid_vec[commit.idx])
    else $error("commit into occupied slot");

  // a granted slot is marked valid right after the commit
  a_commit_sets: assert property (@(posedge clk) disable iff (!rst_n)
    commit.en |=> valid_vec[$past(commit.idx)])
    else $error("committed slot not valid");

endmodule

>>> rtl/core/irt_cell.sv
// One table slot: holds an entry and checks the passing request token against it.
module irt_cell import irt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  token_t           tok_i,
  input  commit_t          commit_i,
  input  release_t         rel_i,
  output token_t           tok_o,
  output logic             valid_o
);

  logic        valid_r;
  logic        valid_nxt;
  logic [1:0]  kind_r;
  logic [31:0] first_r;
  logic [31:0] last_r;
  logic        write_en;
  logic        hit;
  token_t      tok_r;
  token_t      tok_nxt;

  assign write_en = commit_i.en && (commit_i.idx == cell_idx);

  always_comb begin
    valid_nxt = valid_r;
    if (write_en) begin
      valid_nxt = 1'b1;
    end else if (rel_i.en && (rel_i.idx == cell_idx)) begin
      valid_nxt = 1'b0;
    end
  end

  // closed-interval overlap against an entry of the same kind
  assign hit = valid_r && (kind_r == tok_i.kind) &&
               (first_r <= tok_i.last) && (tok_i.first <= last_r);

  always_comb begin
    tok_nxt      = tok_i;
    tok_nxt.busy = tok_i.busy | hit;
    if (!valid_r && !tok_i.free_found) begin
      tok_nxt.free_found = 1'b1;
      tok_nxt.free_idx   = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      tok_r.valid <= tok_i.valid;
    end
    tok_r.kind       <= tok_nxt.kind;
    tok_r.first      <= tok_nxt.first;
    tok_r.last       <= tok_nxt.last;
    tok_r.busy       <= tok_nxt.busy;
    tok_r.free_found <= tok_nxt.free_found;
    tok_r.free_idx   <= tok_nxt.free_idx;
    if (write_en) begin
      kind_r  <= commit_i.kind;
      first_r <= commit_i.first;
      last_r  <= commit_i.last;
    end
  end

  assign tok_o   = tok_r;
  assign valid_o = valid_r;

endmodule
